// ===== sv/spd_pkg.sv =====
// ============================================================================
// spd_pkg: shared types and constants of the spectral derivative unit
// Holds the operation and register codes, the transaction payload structs and
// the width helpers that size the datapath from the grid size NX.
// ============================================================================
package spd_pkg;

    localparam int NX_DEFAULT = 256;

    localparam int STEP_W   = 16;
    localparam int BIN_W    = 8;
    localparam int SAMPLE_W = 24;
    localparam int RESULT_W = 32;
    localparam int FRAC_W   = 12;
    localparam int KY_W     = BIN_W + STEP_W;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd4096;

    typedef enum logic [1:0] {
        OP_DX   = 2'd0,
        OP_DY   = 2'd1,
        OP_DZ   = 2'd2,
        OP_ZERO = 2'd3
    } op_t;

    typedef enum logic {
        CFG_KX_STEP = 1'b0,
        CFG_KY_STEP = 1'b1
    } cfg_index_t;

    typedef struct packed {
        op_t                        operation;
        logic [BIN_W-1:0]           row_bin;
        logic [BIN_W-1:0]           col_bin;
        logic signed [SAMPLE_W-1:0] sample_re;
        logic signed [SAMPLE_W-1:0] sample_im;
    } in_item_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] result_re;
        logic signed [RESULT_W-1:0] result_im;
    } out_item_t;

    // Signed width of the wrapped row index: it spans -NX/2 up to the largest bin.
    function automatic int row_w(input int nx);
        int w;
        w = $clog2(nx) + 1;
        if (w < BIN_W + 1)
        begin
            w = BIN_W + 1;
        end
        return w;
    endfunction

    function automatic int kx_w(input int nx);
        return row_w(nx) + STEP_W;
    endfunction

    // Width of the root of kx^2 + ky^2, rounded up to an even bit count.
    function automatic int root_w(input int nx);
        int a;
        int b;
        int s;
        a = 2 * (kx_w(nx) - 1);
        b = 2 * KY_W;
        s = ((a > b) ? a : b) + 1;
        return ((s + 3) / 4) * 2;
    endfunction

    // Signed width that holds kx, ky and the deep-water root.
    function automatic int factor_w(input int nx);
        int w;
        w = kx_w(nx);
        if (w < KY_W + 1)
        begin
            w = KY_W + 1;
        end
        if (w < root_w(nx) + 1)
        begin
            w = root_w(nx) + 1;
        end
        return w;
    endfunction

endpackage

// ===== sv/spectral_derivative_2d_unit.sv =====
// ============================================================================
// spectral_derivative_2d_unit: spectral derivative of one 2-D Fourier bin
// Multiplies a complex coefficient by i*kx, i*ky or sqrt(kx^2 + ky^2), or
// zeroes it, in Q.12 fixed point, with 32-bit saturated results.
// ============================================================================
// Usage:
//   The input channel carries one coefficient per transaction (operation,
//   row and column bin, 24-bit real and imaginary parts). The output channel
//   returns one transaction with the saturated 32-bit real and imaginary
//   parts, in input order. Both channels use valid and stall; a transaction
//   moves on a rising edge with valid high and stall low.
//   The unit takes one transaction per cycle while in_stall is low. Its stages
//   are four wavenumber and radicand stages, the square-root
//   pipeline that resolves two root bits per stage, and two stages for the
//   multiply and the saturation. The root pipeline sets the depth; every op,
//   not only the deep-water one, runs through it so order is kept.
//   kx_step and ky_step are written over the config port (write enable,
//   index, data); write them only while no transaction is in flight.
//   Reset empties every stage and sets both steps to 1.0 (4096).
//   When the receiver stalls, the output register holds its transaction and
//   stages behind it keep filling bubbles; in_stall rises only once the whole
//   pipeline is full.
// ============================================================================
module spectral_derivative_2d_unit #(
    parameter int NX = spd_pkg::NX_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  spd_pkg::in_item_t                in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output spd_pkg::out_item_t               out_data,
    input  logic                             cfg_write,
    input  spd_pkg::cfg_index_t              cfg_index,
    input  logic [spd_pkg::STEP_W-1:0]       cfg_data
);

    localparam int ROOTW = spd_pkg::root_w(NX);
    localparam int FW    = spd_pkg::factor_w(NX);
    localparam int SW    = spd_pkg::SAMPLE_W;
    localparam int SBW   = 2 + FW + 2 * SW;
    localparam int LAT   = 6 + ROOTW / 2;
    localparam int OCCW  = $clog2(LAT + 1);

    // Configuration registers.
    logic [spd_pkg::STEP_W-1:0] kx_step_reg;
    logic [spd_pkg::STEP_W-1:0] ky_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kx_step_reg <= spd_pkg::STEP_RESET;
            ky_step_reg <= spd_pkg::STEP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                spd_pkg::CFG_KX_STEP: kx_step_reg <= cfg_data;
                spd_pkg::CFG_KY_STEP: ky_step_reg <= cfg_data;
                default:              kx_step_reg <= kx_step_reg;
            endcase
        end
    end

    // Wavenumber section to root pipeline.
    logic                   kg_valid;
    logic                   kg_stall;
    logic [2*ROOTW-1:0]     kg_rad;
    spd_pkg::op_t           kg_op;
    logic signed [FW-1:0]   kg_k;
    logic signed [SW-1:0]   kg_re;
    logic signed [SW-1:0]   kg_im;
    logic [SBW-1:0]         kg_side;

    // Root pipeline to multiply and saturate section.
    logic                   sq_valid;
    logic                   sq_stall;
    logic [ROOTW-1:0]       sq_root;
    logic [SBW-1:0]         sq_side;
    spd_pkg::op_t           sq_op;
    logic signed [FW-1:0]   sq_k;
    logic signed [SW-1:0]   sq_re;
    logic signed [SW-1:0]   sq_im;

    spd_kgen #(
        .NX (NX)
    ) u_kgen (
        .clk       (clk),
        .rst_n     (rst_n),
        .kx_step   (kx_step_reg),
        .ky_step   (ky_step_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (kg_valid),
        .out_stall (kg_stall),
        .out_rad   (kg_rad),
        .out_op    (kg_op),
        .out_k     (kg_k),
        .out_re    (kg_re),
        .out_im    (kg_im)
    );

    // The op, wavenumber and sample ride along the root pipeline as one word.
    assign kg_side = {kg_op, kg_k, kg_re, kg_im};

    spd_isqrt #(
        .ROOTW (ROOTW),
        .SBW   (SBW)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (kg_valid),
        .in_stall  (kg_stall),
        .in_rad    (kg_rad),
        .in_side   (kg_side),
        .out_valid (sq_valid),
        .out_stall (sq_stall),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    assign sq_op = spd_pkg::op_t'(sq_side[SBW-1 -: 2]);
    assign sq_k  = sq_side[2*SW +: FW];
    assign sq_re = sq_side[SW +: SW];
    assign sq_im = sq_side[SW-1:0];

    spd_scale #(
        .FW    (FW),
        .ROOTW (ROOTW)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_stall  (sq_stall),
        .in_op     (sq_op),
        .in_k      (sq_k),
        .in_root   (sq_root),
        .in_re     (sq_re),
        .in_im     (sq_im),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Count of transactions accepted but not yet delivered.
    logic            in_acc;
    logic            out_acc;
    logic [OCCW-1:0] occ_reg;
    logic [OCCW-1:0] occ_next;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    always_comb
    begin
        unique case ({in_acc, out_acc})
            2'b10:   occ_next = occ_reg + 1'b1;
            2'b01:   occ_next = occ_reg - 1'b1;
            default: occ_next = occ_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // The pipeline never holds more transactions than it has stages.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCCW'(LAT))
        else $error("more transactions in flight than pipeline stages");

    // No result appears without an accepted transaction behind it.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == '0) |-> !out_valid)
        else $error("output valid with an empty pipeline");

    // Back-pressure reaches the input only from a stalled, full output.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the output is free");

endmodule

// ===== sv/spd_kgen.sv =====
// ============================================================================
// spd_kgen: wavenumber generation and radicand stages
// Wraps the row bin to a signed index, forms kx and ky, squares them and adds
// the squares for the deep-water root. Four register stages.
// ============================================================================
module spd_kgen #(
    parameter int NX = spd_pkg::NX_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [spd_pkg::STEP_W-1:0]            kx_step,
    input  logic [spd_pkg::STEP_W-1:0]            ky_step,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  spd_pkg::in_item_t                     in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [2*spd_pkg::root_w(NX)-1:0]      out_rad,
    output spd_pkg::op_t                          out_op,
    output logic signed [spd_pkg::factor_w(NX)-1:0] out_k,
    output logic signed [spd_pkg::SAMPLE_W-1:0]   out_re,
    output logic signed [spd_pkg::SAMPLE_W-1:0]   out_im
);

    localparam int RW   = spd_pkg::row_w(NX);
    localparam int KXW  = spd_pkg::kx_w(NX);
    localparam int AXW  = KXW - 1;
    localparam int KYW  = spd_pkg::KY_W;
    localparam int FW   = spd_pkg::factor_w(NX);
    localparam int RADW = 2 * spd_pkg::root_w(NX);
    localparam int SW   = spd_pkg::SAMPLE_W;
    localparam int NST  = 4;

    localparam logic [RW-1:0] HALF_V = RW'(NX / 2);
    localparam logic [RW-1:0] NX_V   = RW'(NX);

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] adv;

    // Stage 1: registered input transaction.
    spd_pkg::in_item_t p1_item_reg;

    // Stage 2: signed kx and unsigned ky.
    spd_pkg::op_t          p2_op_reg;
    logic signed [KXW-1:0] p2_kx_reg;
    logic [KYW-1:0]        p2_ky_reg;
    logic signed [SW-1:0]  p2_re_reg;
    logic signed [SW-1:0]  p2_im_reg;

    // Stage 3: selected wavenumber and the two squares.
    spd_pkg::op_t          p3_op_reg;
    logic signed [FW-1:0]  p3_k_reg;
    logic [2*AXW-1:0]      p3_sqx_reg;
    logic [2*KYW-1:0]      p3_sqy_reg;
    logic signed [SW-1:0]  p3_re_reg;
    logic signed [SW-1:0]  p3_im_reg;

    // Stage 4: radicand, the output register of this section.
    spd_pkg::op_t          p4_op_reg;
    logic [RADW-1:0]       p4_rad_reg;
    logic signed [FW-1:0]  p4_k_reg;
    logic signed [SW-1:0]  p4_re_reg;
    logic signed [SW-1:0]  p4_im_reg;

    logic [RW-1:0]             row_u;
    logic [RW-1:0]             row_adj;
    logic signed [RW+spd_pkg::STEP_W:0] kx_full;
    logic signed [KXW-1:0]     kx_next;
    logic [KYW-1:0]            ky_next;
    logic signed [KXW-1:0]     kx_neg;
    logic [AXW-1:0]            ax;
    logic [2*AXW-1:0]          sqx_next;
    logic [2*KYW-1:0]          sqy_next;
    logic signed [FW-1:0]      k_next;
    logic [RADW-1:0]           rad_next;

    // A stage may load when it is empty or when its content moves on.
    assign adv[NST-1] = !vld_reg[NST-1] || !out_stall;
    genvar gi;
    generate
        for (gi = 0; gi < NST - 1; gi++)
        begin : g_adv
            assign adv[gi] = !vld_reg[gi] || adv[gi+1];
        end
    endgenerate

    assign in_stall = !adv[0];
    assign vld_next = {vld_reg[NST-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    // Rows at or above NX/2 stand for negative wavenumbers.
    always_comb
    begin
        row_u    = {{(RW-spd_pkg::BIN_W){1'b0}}, p1_item_reg.row_bin};
        row_adj  = (row_u >= HALF_V) ? (row_u - NX_V) : row_u;
        kx_full  = $signed(row_adj) * $signed({1'b0, kx_step});
        kx_next  = kx_full[KXW-1:0];
        ky_next  = p1_item_reg.col_bin * ky_step;
    end

    always_comb
    begin
        kx_neg   = -p2_kx_reg;
        ax       = p2_kx_reg[KXW-1] ? kx_neg[AXW-1:0] : p2_kx_reg[AXW-1:0];
        sqx_next = ax * ax;
        sqy_next = p2_ky_reg * p2_ky_reg;
        k_next   = (p2_op_reg == spd_pkg::OP_DX) ? FW'(p2_kx_reg)
                                                 : $signed(FW'(p2_ky_reg));
    end

    assign rad_next = RADW'(p3_sqx_reg) + RADW'(p3_sqy_reg);

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            p1_item_reg <= in_data;
        end
        if (adv[1])
        begin
            p2_op_reg <= p1_item_reg.operation;
            p2_kx_reg <= kx_next;
            p2_ky_reg <= ky_next;
            p2_re_reg <= p1_item_reg.sample_re;
            p2_im_reg <= p1_item_reg.sample_im;
        end
        if (adv[2])
        begin
            p3_op_reg  <= p2_op_reg;
            p3_k_reg   <= k_next;
            p3_sqx_reg <= sqx_next;
            p3_sqy_reg <= sqy_next;
            p3_re_reg  <= p2_re_reg;
            p3_im_reg  <= p2_im_reg;
        end
        if (adv[3])
        begin
            p4_op_reg  <= p3_op_reg;
            p4_rad_reg <= rad_next;
            p4_k_reg   <= p3_k_reg;
            p4_re_reg  <= p3_re_reg;
            p4_im_reg  <= p3_im_reg;
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign out_rad   = p4_rad_reg;
    assign out_op    = p4_op_reg;
    assign out_k     = p4_k_reg;
    assign out_re    = p4_re_reg;
    assign out_im    = p4_im_reg;

endmodule

// ===== sv/spd_isqrt.sv =====
// ============================================================================
// spd_isqrt: pipelined integer square root
// Digit-by-digit restoring root, two result bits per register stage. A
// sideband word travels alongside each radicand unchanged.
// ============================================================================
module spd_isqrt #(
    parameter int ROOTW = spd_pkg::root_w(spd_pkg::NX_DEFAULT),
    parameter int SBW   = 2 + spd_pkg::factor_w(spd_pkg::NX_DEFAULT) + 2 * spd_pkg::SAMPLE_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [2*ROOTW-1:0]   in_rad,
    input  logic [SBW-1:0]       in_side,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [ROOTW-1:0]     out_root,
    output logic [SBW-1:0]       out_side
);

    localparam int NS   = ROOTW / 2;
    localparam int RADW = 2 * ROOTW;
    localparam int RMW  = ROOTW + 1;
    localparam int TW   = RMW + 2;
    localparam int STW  = RMW + ROOTW + RADW;

    logic [RMW-1:0]   rem_reg  [NS];
    logic [ROOTW-1:0] root_reg [NS];
    logic [RADW-1:0]  rad_reg  [NS];
    logic [SBW-1:0]   side_reg [NS];
    logic [NS-1:0]    vld_reg;
    logic [NS-1:0]    adv;

    // Two root digits; for each, bring down two radicand bits and try (root << 2) | 1.
    function automatic logic [STW-1:0] step2(
        input logic [RMW-1:0]   rem,
        input logic [ROOTW-1:0] root,
        input logic [RADW-1:0]  rad
    );
        logic [TW-1:0]    t;
        logic [TW-1:0]    trial;
        logic [RMW-1:0]   r;
        logic [ROOTW-1:0] q;
        logic [RADW-1:0]  d;
        r = rem;
        q = root;
        d = rad;
        for (int j = 0; j < 2; j++)
        begin
            t     = {r, d[RADW-1 -: 2]};
            trial = TW'({q, 2'b01});
            if (t >= trial)
            begin
                t = t - trial;
                q = {q[ROOTW-2:0], 1'b1};
            end
            else
            begin
                q = {q[ROOTW-2:0], 1'b0};
            end
            r = t[RMW-1:0];
            d = {d[RADW-3:0], 2'b00};
        end
        return {r, q, d};
    endfunction

    assign adv[NS-1] = !vld_reg[NS-1] || !out_stall;
    assign in_stall  = !adv[0];

    genvar gs;
    generate
        for (gs = 0; gs < NS; gs++)
        begin : g_stage
            logic [RMW-1:0]   rem_in;
            logic [ROOTW-1:0] root_in;
            logic [RADW-1:0]  rad_in;
            logic [SBW-1:0]   side_in;
            logic             vld_in;
            logic [STW-1:0]   res;

            if (gs == 0)
            begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign rad_in  = in_rad;
                assign side_in = in_side;
                assign vld_in  = in_valid;
            end
            else
            begin : g_rest
                assign rem_in  = rem_reg[gs-1];
                assign root_in = root_reg[gs-1];
                assign rad_in  = rad_reg[gs-1];
                assign side_in = side_reg[gs-1];
                assign vld_in  = vld_reg[gs-1];
            end

            if (gs < NS - 1)
            begin : g_adv
                assign adv[gs] = !vld_reg[gs] || adv[gs+1];
            end

            assign res = step2(rem_in, root_in, rad_in);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[gs] <= 1'b0;
                end
                else if (adv[gs])
                begin
                    vld_reg[gs] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv[gs])
                begin
                    rem_reg[gs]  <= res[STW-1 -: RMW];
                    root_reg[gs] <= res[RADW +: ROOTW];
                    rad_reg[gs]  <= res[RADW-1:0];
                    side_reg[gs] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[NS-1];
    assign out_root  = root_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

// ===== sv/spd_scale.sv =====
// ============================================================================
// spd_scale: wavenumber multiply, Q.12 floor and saturation
// One stage multiplies the sample by i*k or by the root; the next floors and
// saturates to 32 bits (zero for OP_ZERO) and holds the output transaction.
// ============================================================================
module spd_scale #(
    parameter int FW    = spd_pkg::factor_w(spd_pkg::NX_DEFAULT),
    parameter int ROOTW = spd_pkg::root_w(spd_pkg::NX_DEFAULT)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  spd_pkg::op_t                        in_op,
    input  logic signed [FW-1:0]                in_k,
    input  logic [ROOTW-1:0]                    in_root,
    input  logic signed [spd_pkg::SAMPLE_W-1:0] in_re,
    input  logic signed [spd_pkg::SAMPLE_W-1:0] in_im,
    output logic                                out_valid,
    input  logic                                out_stall,
    output spd_pkg::out_item_t                  out_data
);

    localparam int SW  = spd_pkg::SAMPLE_W + 1;
    localparam int PW  = FW + SW;
    localparam int QW  = PW - spd_pkg::FRAC_W;
    localparam int RSW = spd_pkg::RESULT_W;

    localparam logic signed [RSW-1:0] RES_MAX = {1'b0, {(RSW-1){1'b1}}};
    localparam logic signed [RSW-1:0] RES_MIN = {1'b1, {(RSW-1){1'b0}}};

    logic [1:0] vld_reg;
    logic [1:0] adv;

    spd_pkg::op_t          a_op_reg;
    logic signed [PW-1:0]  a_pa_reg;
    logic signed [PW-1:0]  a_pb_reg;
    spd_pkg::out_item_t    out_reg;

    logic signed [FW-1:0]  fac;
    logic signed [SW-1:0]  re_x;
    logic signed [SW-1:0]  im_x;
    logic signed [SW-1:0]  ma;
    logic signed [SW-1:0]  mb;
    logic signed [PW-1:0]  pa_next;
    logic signed [PW-1:0]  pb_next;
    spd_pkg::out_item_t    out_next;

    // Floor by 2^12 is the arithmetic shift; then clamp to 32 bits.
    function automatic logic signed [RSW-1:0] sat_shift(input logic signed [PW-1:0] p);
        logic [QW-1:0]     q;
        logic [QW-RSW:0]   hi;
        logic signed [RSW-1:0] r;
        q  = p[PW-1:spd_pkg::FRAC_W];
        hi = q[QW-1:RSW-1];
        if ((&hi) || !(|hi))
        begin
            r = q[RSW-1:0];
        end
        else if (q[QW-1])
        begin
            r = RES_MIN;
        end
        else
        begin
            r = RES_MAX;
        end
        return r;
    endfunction

    assign adv[1]   = !vld_reg[1] || !out_stall;
    assign adv[0]   = !vld_reg[0] || adv[1];
    assign in_stall = !adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            if (adv[1])
            begin
                vld_reg[1] <= vld_reg[0];
            end
        end
    end

    // i*k*(re + i*im) = -k*im + i*k*re; the deep-water root scales both parts.
    always_comb
    begin
        re_x = SW'(in_re);
        im_x = SW'(in_im);
        if (in_op == spd_pkg::OP_DZ)
        begin
            fac = $signed(FW'(in_root));
            ma  = re_x;
            mb  = im_x;
        end
        else
        begin
            fac = in_k;
            ma  = -im_x;
            mb  = re_x;
        end
        pa_next = fac * ma;
        pb_next = fac * mb;
    end

    always_comb
    begin
        if (a_op_reg == spd_pkg::OP_ZERO)
        begin
            out_next.result_re = '0;
            out_next.result_im = '0;
        end
        else
        begin
            out_next.result_re = sat_shift(a_pa_reg);
            out_next.result_im = sat_shift(a_pb_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            a_op_reg <= in_op;
            a_pa_reg <= pa_next;
            a_pb_reg <= pb_next;
        end
        if (adv[1])
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = vld_reg[1];
    assign out_data  = out_reg;

endmodule
